// ===== hw/rtl/tpefsd_pkg.sv =====
package tpefsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int SRV_W       = $clog2(MAX_SERVERS);
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int TIME_W      = 32;
    localparam int ADDR_W      = 1 + SRV_W;
    localparam int DEPTH       = 2 * MAX_SERVERS;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SERVERS);

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRI_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NRM_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PRI_SVC   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NRM_SVC   = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OVR,
        ST_UPD
    } t_state;

    // Requests from the scheduler to the state memories
    typedef struct packed {
        logic              nf_rd_en;
        logic [ADDR_W-1:0] nf_rd_addr;
        logic              nf_we;
        logic [ADDR_W-1:0] nf_waddr;
        logic [TIME_W-1:0] nf_wdata;
        logic              ov_rd_en;
        logic [ADDR_W-1:0] ov_rd_addr;
        logic              ov_we;
        logic [ADDR_W-1:0] ov_waddr;
        logic [TIME_W-1:0] ov_wdata;
    } t_mem_req;

    // Registered read data, valid in the cycle after the request
    typedef struct packed {
        logic [TIME_W-1:0] nf_data;
        logic [TIME_W-1:0] ov_data;
        logic              ov_vld;
    } t_mem_rsp;

endpackage

// ===== hw/rtl/tpefsd_store.sv =====
module tpefsd_store
    import tpefsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [TIME_W-1:0] r_nf_mem [DEPTH];
    logic [TIME_W-1:0] r_ov_mem [DEPTH];
    logic [DEPTH-1:0]  r_nf_written;
    logic [DEPTH-1:0]  r_ov_valid;
    logic [TIME_W-1:0] r_nf_q;
    logic              r_nf_wr_q;
    logic [TIME_W-1:0] r_ov_q;
    logic              r_ov_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_req.nf_we) begin
            r_nf_mem[i_req.nf_waddr] <= i_req.nf_wdata;
        end
        if (i_req.nf_rd_en) begin
            r_nf_q <= r_nf_mem[i_req.nf_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ov_we) begin
            r_ov_mem[i_req.ov_waddr] <= i_req.ov_wdata;
        end
        if (i_req.ov_rd_en) begin
            r_ov_q <= r_ov_mem[i_req.ov_rd_addr];
        end
    end

    // Track entries written since reset; unwritten next-free entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf_written <= '0;
            r_ov_valid   <= '0;
            r_nf_wr_q    <= 1'b0;
            r_ov_vld_q   <= 1'b0;
        end else begin
            if (i_req.nf_we) begin
                r_nf_written[i_req.nf_waddr] <= 1'b1;
            end
            if (i_req.ov_we) begin
                r_ov_valid[i_req.ov_waddr] <= 1'b1;
            end
            if (i_req.nf_rd_en) begin
                r_nf_wr_q <= r_nf_written[i_req.nf_rd_addr];
            end
            if (i_req.ov_rd_en) begin
                r_ov_vld_q <= r_ov_valid[i_req.ov_rd_addr];
            end
        end
    end

    assign o_rsp.nf_data = r_nf_wr_q ? r_nf_q : '0;
    assign o_rsp.ov_data = r_ov_q;
    assign o_rsp.ov_vld  = r_ov_vld_q;

endmodule

// ===== hw/rtl/tpefsd_sched.sv =====
module tpefsd_sched
    import tpefsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_op,
    input  logic              i_pool,
    input  logic [IDX_W-1:0]  i_server_index,
    input  logic [TIME_W-1:0] i_time_value,
    input  logic [CNT_W-1:0]  i_pri_count,
    input  logic [CNT_W-1:0]  i_nrm_count,
    input  logic [TIME_W-1:0] i_pri_svc,
    input  logic [TIME_W-1:0] i_nrm_svc,
    output t_mem_req          o_req,
    input  t_mem_rsp          i_rsp,
    output logic              o_valid,
    output logic [TIME_W-1:0] o_exit_time,
    output logic [IDX_W-1:0]  o_chosen_server,
    output logic              o_result_pool,
    output logic [1:0]        o_status
);

    t_state            r_state, n_state;
    logic              r_pool, n_pool;
    logic [TIME_W-1:0] r_tv, n_tv;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_pend, n_pend;
    logic              r_have_best, n_have_best;
    logic              r_free, n_free;
    logic [TIME_W-1:0] r_best, n_best;
    logic [SRV_W-1:0]  r_pick, n_pick;

    logic              r_out_vld, n_out_vld;
    logic [TIME_W-1:0] r_out_exit, n_out_exit;
    logic [IDX_W-1:0]  r_out_srv, n_out_srv;
    logic              r_out_pool, n_out_pool;
    logic [1:0]        r_out_stat, n_out_stat;

    logic              accept;
    logic [CNT_W-1:0]  raw_cnt;
    logic [CNT_W-1:0]  in_cnt;
    logic [TIME_W-1:0] svc;
    logic [TIME_W-1:0] base;
    logic [TIME_W:0]   sum;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign raw_cnt = i_pool ? i_nrm_count : i_pri_count;
    assign in_cnt  = (raw_cnt > CNT_MAX) ? CNT_MAX : raw_cnt;

    assign svc  = i_rsp.ov_vld ? i_rsp.ov_data : (r_pool ? i_nrm_svc : i_pri_svc);
    assign base = r_free ? r_tv : r_best;
    assign sum  = {1'b0, base} + {1'b0, svc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool      <= n_pool;
        r_tv        <= n_tv;
        r_cnt       <= n_cnt;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_have_best <= n_have_best;
        r_free      <= n_free;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_out_exit  <= n_out_exit;
        r_out_srv   <= n_out_srv;
        r_out_pool  <= n_out_pool;
        r_out_stat  <= n_out_stat;
    end

    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_tv        = r_tv;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = 1'b0;
        n_have_best = r_have_best;
        n_free      = r_free;
        n_best      = r_best;
        n_pick      = r_pick;
        n_out_vld   = 1'b0;
        n_out_exit  = r_out_exit;
        n_out_srv   = r_out_srv;
        n_out_pool  = r_out_pool;
        n_out_stat  = r_out_stat;
        o_req       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pool = i_pool;
                    n_tv   = i_time_value;
                    n_cnt  = in_cnt;
                    if (i_op == OP_SET) begin
                        if ({1'b0, i_server_index} >= in_cnt) begin
                            n_out_vld  = 1'b1;
                            n_out_exit = '0;
                            n_out_srv  = i_server_index;
                            n_out_pool = i_pool;
                            n_out_stat = STAT_RANGE;
                        end else begin
                            o_req.ov_we    = 1'b1;
                            o_req.ov_waddr = {i_pool, i_server_index[SRV_W-1:0]};
                            o_req.ov_wdata = i_time_value;
                        end
                    end else if (in_cnt == '0) begin
                        n_out_vld  = 1'b1;
                        n_out_exit = '0;
                        n_out_srv  = '0;
                        n_out_pool = i_pool;
                        n_out_stat = STAT_RANGE;
                    end else begin
                        n_state     = ST_SCAN;
                        n_rd_idx    = '0;
                        n_have_best = 1'b0;
                        n_free      = 1'b0;
                        n_pick      = '0;
                        n_best      = '0;
                    end
                end
            end

            ST_SCAN: begin
                if (r_pend) begin
                    if (r_tv >= i_rsp.nf_data) begin
                        n_pick  = r_cmp_idx[SRV_W-1:0];
                        n_free  = 1'b1;
                        n_state = ST_OVR;
                    end else begin
                        if (!r_have_best || (i_rsp.nf_data < r_best)) begin
                            n_best      = i_rsp.nf_data;
                            n_pick      = r_cmp_idx[SRV_W-1:0];
                            n_have_best = 1'b1;
                        end
                        if (r_cmp_idx + CNT_W'(1) == r_cnt) begin
                            n_state = ST_OVR;
                        end
                    end
                end
                // Keep one read in flight ahead of the compare
                if (r_rd_idx < r_cnt) begin
                    o_req.nf_rd_en   = 1'b1;
                    o_req.nf_rd_addr = {r_pool, r_rd_idx[SRV_W-1:0]};
                    n_rd_idx         = r_rd_idx + CNT_W'(1);
                    n_cmp_idx        = r_rd_idx;
                    n_pend           = (n_state == ST_SCAN);
                end
            end

            ST_OVR: begin
                o_req.ov_rd_en   = 1'b1;
                o_req.ov_rd_addr = {r_pool, r_pick};
                n_state          = ST_UPD;
            end

            ST_UPD: begin
                o_req.nf_we    = 1'b1;
                o_req.nf_waddr = {r_pool, r_pick};
                o_req.nf_wdata = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                n_out_vld      = 1'b1;
                n_out_exit     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                n_out_srv      = IDX_W'(r_pick);
                n_out_pool     = r_pool;
                n_out_stat     = sum[TIME_W] ? STAT_SAT : STAT_OK;
                n_state        = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_out_vld;
    assign o_exit_time     = r_out_exit;
    assign o_chosen_server = r_out_srv;
    assign o_result_pool   = r_out_pool;
    assign o_status        = r_out_stat;

endmodule

// ===== hw/rtl/two_pool_earliest_free_server_dispatch_unit.sv =====
// Channel   Direction  Handshake                       Payload
// command   in         start & !busy                   i_op, i_pool, i_server_index,
//                                                      i_time_value
// result    out        o_valid, one cycle, no stall    o_exit_time, o_chosen_server,
//                                                      o_result_pool, o_status
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_index, i_cfg_data
//
// A set, an out-of-range set or an empty-pool arrival keeps busy low; any result shows next cycle.
// An arrival scans the pool up to the first free server, or through all count servers when none
// is free: one next-free read per server feeds one comparator, then the override memory is read,
// then the next-free entry is written back and the result driven.
// Reset (i_rst_n low, synchronous) restores the config defaults and clears the valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_pool_earliest_free_server_dispatch_unit
    import tpefsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic                 i_pool,
    input  logic [IDX_W-1:0]     i_server_index,
    input  logic [TIME_W-1:0]    i_time_value,
    // result
    output logic                 o_valid,
    output logic [TIME_W-1:0]    o_exit_time,
    output logic [IDX_W-1:0]     o_chosen_server,
    output logic                 o_result_pool,
    output logic [1:0]           o_status,
    // config
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    logic [CNT_W-1:0]  r_pri_count;
    logic [CNT_W-1:0]  r_nrm_count;
    logic [TIME_W-1:0] r_pri_svc;
    logic [TIME_W-1:0] r_nrm_svc;
    logic              cfg_we;
    t_mem_req          mem_req;
    t_mem_rsp          mem_rsp;

    // Config registers take every write directly, so the port is always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_count <= CNT_W'(1);
            r_nrm_count <= CNT_W'(1);
            r_pri_svc   <= TIME_W'(1);
            r_nrm_svc   <= TIME_W'(1);
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_PRI_COUNT: r_pri_count <= i_cfg_data[CNT_W-1:0];
                CFG_NRM_COUNT: r_nrm_count <= i_cfg_data[CNT_W-1:0];
                CFG_PRI_SVC:   r_pri_svc   <= i_cfg_data;
                CFG_NRM_SVC:   r_nrm_svc   <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Scan, select and write-back sequencer
    tpefsd_sched u_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_op            (i_op),
        .i_pool          (i_pool),
        .i_server_index  (i_server_index),
        .i_time_value    (i_time_value),
        .i_pri_count     (r_pri_count),
        .i_nrm_count     (r_nrm_count),
        .i_pri_svc       (r_pri_svc),
        .i_nrm_svc       (r_nrm_svc),
        .o_req           (mem_req),
        .i_rsp           (mem_rsp),
        .o_valid         (o_valid),
        .o_exit_time     (o_exit_time),
        .o_chosen_server (o_chosen_server),
        .o_result_pool   (o_result_pool),
        .o_status        (o_status)
    );

    // Next-free and override memories, both pools side by side
    tpefsd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

endmodule

// ===== tb/tb_two_pool_earliest_free_server_dispatch_unit.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the two-pool dispatch unit.
module tb_two_pool_earliest_free_server_dispatch_unit;
    import tpefsd_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 3;
    // Leave margin after the longest arrival before touching registers.
    localparam int     SETTLE_CYCLES = 24;
    localparam int     NUM_PHASES    = 10;
    localparam int     PHASE_ITEMS   = 130;
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS    = 4_000_000;

    localparam logic                 POOL_PRI        = 1'b0;
    localparam logic                 POOL_NRM        = 1'b1;
    localparam logic [TIME_W-1:0]    TIME_MAX        = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_NRM_SVC + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct {
        logic [TIME_W-1:0] exit_time;
        logic [IDX_W-1:0]  server;
        logic              pool;
        logic [1:0]        status;
    } t_dispatch;

    typedef struct {
        bit                   is_cfg;
        bit                   typed;
        logic                 op;
        logic                 pool;
        logic [IDX_W-1:0]     idx;
        logic [TIME_W-1:0]    value;
        logic [CFG_IDX_W-1:0] cfg_idx;
        t_dispatch            want;
    } t_stim_row;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_op = OP_SET;
    logic                 i_pool = POOL_PRI;
    logic [IDX_W-1:0]     i_server_index = '0;
    logic [TIME_W-1:0]    i_time_value = '0;
    logic                 o_valid;
    logic [TIME_W-1:0]    o_exit_time;
    logic [IDX_W-1:0]     o_chosen_server;
    logic                 o_result_pool;
    logic [1:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    // Shadow copy of the dispatcher state and registers
    logic [TIME_W-1:0] server_free_at [2][MAX_SERVERS];
    logic [TIME_W-1:0] server_svc     [2][MAX_SERVERS];
    bit                server_svc_set [2][MAX_SERVERS];
    logic [CNT_W-1:0]  pool_count_reg [2];
    logic [TIME_W-1:0] pool_default   [2];

    t_dispatch  pending_dispatch_q[$];
    t_stim_row  stim_table[$];

    int error_count   = 0;
    int results_seen  = 0;
    int arrivals_sent = 0;
    int sets_sent     = 0;
    int sat_seen      = 0;
    int reject_seen   = 0;
    logic [TIME_W-1:0] time_base;

    two_pool_earliest_free_server_dispatch_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_pool          (i_pool),
        .i_server_index  (i_server_index),
        .i_time_value    (i_time_value),
        .o_valid         (o_valid),
        .o_exit_time     (o_exit_time),
        .o_chosen_server (o_chosen_server),
        .o_result_pool   (o_result_pool),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Hard stop in case a handshake or a result never arrives
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Append to the tail of the expected-result and stimulus queues
    function automatic void queue_result(input t_dispatch d);
        pending_dispatch_q.insert(pending_dispatch_q.size(), d);
    endfunction

    function automatic void queue_row(input t_stim_row row);
        stim_table.insert(stim_table.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Dispatch predictor
    // ------------------------------------------------------------------
    function automatic void reset_dispatch_model();
        for (int p = 0; p < 2; p++) begin
            for (int s = 0; s < MAX_SERVERS; s++) begin
                server_free_at[p][s] = '0;
                server_svc[p][s]     = '0;
                server_svc_set[p][s] = 1'b0;
            end
            pool_count_reg[p] = CNT_W'(1);
            pool_default[p]   = TIME_W'(1);
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [TIME_W-1:0] data);
        case (idx)
            CFG_PRI_COUNT: pool_count_reg[POOL_PRI] = data[CNT_W-1:0];
            CFG_NRM_COUNT: pool_count_reg[POOL_NRM] = data[CNT_W-1:0];
            CFG_PRI_SVC:   pool_default[POOL_PRI]   = data;
            CFG_NRM_SVC:   pool_default[POOL_NRM]   = data;
            default: ;
        endcase
    endfunction

    // Return 1 when the item produces a result, with that result in res.
    function automatic bit predict_dispatch(input logic op, input logic pool,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [TIME_W-1:0] tv,
                                            output t_dispatch res);
        int                cnt;
        int                pick;
        bit                found;
        bit                have_best;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] svc;
        logic [TIME_W:0]   sum;
        cnt       = (int'(pool_count_reg[pool]) > MAX_SERVERS) ? MAX_SERVERS
                                                               : int'(pool_count_reg[pool]);
        pick      = 0;
        found     = 1'b0;
        have_best = 1'b0;
        best      = '0;
        res       = '{'0, '0, pool, STAT_OK};

        if (op == OP_SET) begin
            if (int'(idx) >= cnt) begin
                res = '{'0, idx, pool, STAT_RANGE};
                return 1'b1;
            end
            server_svc[pool][idx]     = tv;
            server_svc_set[pool][idx] = 1'b1;
            return 1'b0;
        end

        if (cnt == 0) begin
            res = '{'0, '0, pool, STAT_RANGE};
            return 1'b1;
        end

        // First free server wins; otherwise track the earliest next-free time
        for (int i = 0; i < cnt; i++) begin
            if (!found) begin
                if (tv >= server_free_at[pool][i]) begin
                    pick  = i;
                    found = 1'b1;
                end else if (!have_best || server_free_at[pool][i] < best) begin
                    best      = server_free_at[pool][i];
                    pick      = i;
                    have_best = 1'b1;
                end
            end
        end

        base = found ? tv : server_free_at[pool][pick];
        svc  = server_svc_set[pool][pick] ? server_svc[pool][pick] : pool_default[pool];
        sum  = {1'b0, base} + {1'b0, svc};
        if (sum[TIME_W]) begin
            server_free_at[pool][pick] = TIME_MAX;
            res = '{TIME_MAX, IDX_W'(pick), pool, STAT_SAT};
        end else begin
            server_free_at[pool][pick] = sum[TIME_W-1:0];
            res = '{sum[TIME_W-1:0], IDX_W'(pick), pool, STAT_OK};
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: all inputs change on the falling edge
    // ------------------------------------------------------------------
    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Present one item and hold it until the block takes it.
    task automatic issue_command(input logic op, input logic pool,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] tv,
                                 input bit typed, input t_dispatch want);
        t_dispatch predicted;
        bit        has_result;
        @(negedge i_clk);
        start          = 1'b1;
        i_op           = op;
        i_pool         = pool;
        i_server_index = idx;
        i_time_value   = tv;
        do @(posedge i_clk); while (busy);
        // Advance the shadow state even where the expected result is typed in
        has_result = predict_dispatch(op, pool, idx, tv, predicted);
        if (typed)
            queue_result(want);
        else if (has_result)
            queue_result(predicted);
        if (op == OP_ARRIVE)
            arrivals_sent++;
        else
            sets_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drop start, drain every outstanding result, then let the block settle.
    task automatic wait_for_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_dispatch_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_cmd(input logic op, input logic pool,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [TIME_W-1:0] tv);
        t_stim_row row;
        row = '{1'b0, 1'b0, op, pool, idx, tv, '0, '{'0, '0, pool, STAT_OK}};
        queue_row(row);
    endfunction

    function automatic void add_checked(input logic op, input logic pool,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [TIME_W-1:0] tv,
                                        input logic [TIME_W-1:0] exit_time,
                                        input logic [IDX_W-1:0] server,
                                        input logic [1:0] status);
        t_stim_row row;
        row = '{1'b0, 1'b1, op, pool, idx, tv, '0, '{exit_time, server, pool, status}};
        queue_row(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TIME_W-1:0] data);
        t_stim_row row;
        row = '{1'b1, 1'b0, OP_SET, POOL_PRI, '0, data, idx, '{'0, '0, POOL_PRI, STAT_OK}};
        queue_row(row);
    endfunction

    // ------------------------------------------------------------------
    // Random value pickers
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TIME_W'(1);
            2:       return TIME_W'(MAX_SERVERS);
            3:       return TIME_W'($urandom_range(MAX_SERVERS + 1, 31));
            4:       return $urandom;
            default: return TIME_W'($urandom_range(2, MAX_SERVERS - 1));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_service();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TIME_MAX;
            2:       return $urandom;
            default: return TIME_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Arrivals mostly track a slowly moving time base so servers queue up.
    function automatic logic [TIME_W-1:0] pick_arrival();
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return TIME_MAX - TIME_W'($urandom_range(0, 3));
            2:       return $urandom;
            default: begin
                time_base = time_base + TIME_W'($urandom_range(0, 6));
                return time_base + TIME_W'($urandom_range(0, 3));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: sample on the rising edge, compare against the oldest
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dispatch want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_status == STAT_SAT)
                sat_seen++;
            if (o_status == STAT_RANGE)
                reject_seen++;
            if (pending_dispatch_q.size() == 0) begin
                report_failure($sformatf("unexpected result exit=%h srv=%0d pool=%0d st=%0d",
                                         o_exit_time, o_chosen_server, o_result_pool,
                                         o_status));
            end else begin
                want = pending_dispatch_q.pop_front();
                if (o_exit_time !== want.exit_time || o_chosen_server !== want.server ||
                    o_result_pool !== want.pool || o_status !== want.status)
                    report_failure($sformatf(
                        "exp exit=%h srv=%0d pool=%0d st=%0d, got exit=%h srv=%0d pool=%0d st=%0d",
                        want.exit_time, want.server, want.pool, want.status,
                        o_exit_time, o_chosen_server, o_result_pool, o_status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int burst;
        int sent;
        logic op;
        logic [TIME_W-1:0] tv;
        t_dispatch none;

        none = '{'0, '0, POOL_PRI, STAT_OK};
        reset_dispatch_model();

        // Hold reset, then release it on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Reset values: one server per pool, service time one.
        add_checked(OP_ARRIVE, POOL_PRI, 4'd0, '0, TIME_W'(1), 4'd0, STAT_OK);
        // Arrival at the top of the time range saturates
        add_checked(OP_ARRIVE, POOL_NRM, 4'd9, TIME_MAX, TIME_MAX, 4'd0, STAT_SAT);
        // Server now pinned at the maximum: queued job saturates as well
        add_checked(OP_ARRIVE, POOL_NRM, 4'd0, TIME_W'(5), TIME_MAX, 4'd0, STAT_SAT);
        // Set beyond the pool's server count is rejected and echoes the index
        add_checked(OP_SET, POOL_PRI, 4'd1, TIME_W'(77), '0, 4'd1, STAT_RANGE);
        add_checked(OP_SET, POOL_PRI, 4'd15, TIME_MAX, '0, 4'd15, STAT_RANGE);
        add_cmd(OP_SET, POOL_PRI, 4'd0, TIME_W'(100));
        add_cmd(OP_ARRIVE, POOL_PRI, 4'd3, '0);
        // Empty pool: arrivals and sets both rejected
        add_reg(CFG_PRI_COUNT, '0);
        add_checked(OP_ARRIVE, POOL_PRI, 4'd6, TIME_W'(7), '0, 4'd0, STAT_RANGE);
        add_checked(OP_SET, POOL_PRI, 4'd0, TIME_W'(7), '0, 4'd0, STAT_RANGE);
        // Full pools, one count above the maximum, extreme default services
        add_reg(CFG_PRI_COUNT, TIME_W'(MAX_SERVERS));
        add_reg(CFG_NRM_COUNT, TIME_W'(31));
        add_reg(CFG_PRI_SVC, '0);
        add_reg(CFG_NRM_SVC, TIME_MAX);
        add_cmd(OP_SET, POOL_PRI, 4'd15, TIME_MAX);
        add_cmd(OP_ARRIVE, POOL_PRI, 4'd0, '0);
        add_cmd(OP_SET, POOL_NRM, 4'd15, TIME_W'(3));
        add_cmd(OP_SET, POOL_NRM, 4'd2, '0);
        add_cmd(OP_ARRIVE, POOL_NRM, 4'd15, TIME_MAX);
        // Exactly reaches the maximum without passing it
        add_cmd(OP_ARRIVE, POOL_NRM, 4'd0, '0);
        add_cmd(OP_ARRIVE, POOL_NRM, 4'd0, '0);
        add_reg(CFG_PRI_SVC, TIME_MAX);
        add_reg(CFG_SPARE_FIRST, $urandom);
        add_reg(CFG_SPARE_LAST, $urandom);
        add_reg(CFG_NRM_SVC, TIME_W'(1));
        add_cmd(OP_ARRIVE, POOL_PRI, 4'd0, TIME_MAX - TIME_W'(1));
        add_cmd(OP_ARRIVE, POOL_PRI, 4'd0, TIME_W'(2));
        add_cmd(OP_ARRIVE, POOL_NRM, 4'd0, TIME_W'(1));
        add_cmd(OP_ARRIVE, POOL_NRM, 4'd0, TIME_W'(1));

        foreach (stim_table[r]) begin
            if (stim_table[r].is_cfg) begin
                wait_for_idle();
                write_register(stim_table[r].cfg_idx, stim_table[r].value);
            end else begin
                issue_command(stim_table[r].op, stim_table[r].pool, stim_table[r].idx,
                              stim_table[r].value, stim_table[r].typed, stim_table[r].want);
            end
        end

        // Random part: one register setting per phase, bursts of items with gaps
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_idle();
            write_register(CFG_PRI_COUNT, pick_count());
            write_register(CFG_NRM_COUNT, pick_count());
            write_register(CFG_PRI_SVC, pick_service());
            write_register(CFG_NRM_SVC, pick_service());
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                               $urandom);

            // Push the time base up each phase; the last one runs near the top
            if (phase == NUM_PHASES - 1)
                time_base = TIME_MAX - TIME_W'(400);
            else
                time_base = TIME_W'(phase) * 32'h1800_0000 + TIME_W'($urandom_range(0, 1000));

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    op = ($urandom_range(0, 4) == 0) ? OP_SET : OP_ARRIVE;
                    tv = (op == OP_SET) ? pick_service() : pick_arrival();
                    issue_command(op, 1'($urandom_range(0, 1)),
                                  IDX_W'($urandom_range(0, 15)), tv, 1'b0, none);
                    sent++;
                end
                // Mostly short gaps, sometimes none, now and then a long one
                if ($urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(5, 30));
                else
                    idle_cycles($urandom_range(0, 3));
            end
        end

        // Drain and give the block time to show any stray result
        wait_for_idle();

        $display("Sent %0d arrivals and %0d service-time sets over %0d register phases.",
                 arrivals_sent, sets_sent, NUM_PHASES);
        $display("Checked %0d results: %0d saturated, %0d rejected.",
                 results_seen, sat_seen, reject_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
